### hw/rtl/lsfc_pkg.sv
package lsfc_pkg;

    localparam int POS_W         = 32;
    localparam int D_W           = POS_W + 1;
    localparam int Q_W           = 16;
    localparam int QZ_W          = 15;
    localparam int PROD_W        = 2 * Q_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int M_W           = 20;
    localparam int MUL_W         = M_W + D_W;
    localparam int B_W           = MUL_W + 2;
    localparam int CW            = B_W + 3;
    localparam int ZW            = 23;
    localparam int GAIN_W        = 16;
    localparam int GMUL_W        = ZW + GAIN_W;
    localparam int FIN_W         = 14;
    localparam int INC_W         = 15;
    localparam int THR_W         = 16;
    localparam int ANG_W         = 15;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 16;
    localparam int CORDIC_STEPS  = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int STEP_W        = $clog2(ANG_TABLE_LEN);
    localparam int N_PROD        = 10;
    localparam int N_MAC         = 9;
    localparam int CNT_W         = 4;
    localparam int ANG_HALF_PI   = 1647099;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_UP   = 2'd1,
        CMD_DOWN = 2'd2,
        CMD_STOP = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PITCH_GAIN = 3'd0,
        REG_YAW_GAIN   = 3'd1,
        REG_FIN_LIMIT  = 3'd2,
        REG_THRUST_INC = 3'd3,
        REG_THRUST_MAX = 3'd4,
        REG_THRUST_MIN = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_ROT,
        T_CORD,
        T_FIN,
        T_DONE
    } top_state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_PROD,
        R_MAC
    } rot_state_t;

    typedef struct packed {
        logic                 vld;
        logic                 tag;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cord_t;

    function automatic logic signed [ZW-1:0] atan_q20(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] a;
        begin
            case (i)
                5'd0:    a = ZW'(823550);
                5'd1:    a = ZW'(486170);
                5'd2:    a = ZW'(256879);
                5'd3:    a = ZW'(130396);
                5'd4:    a = ZW'(65451);
                5'd5:    a = ZW'(32757);
                5'd6:    a = ZW'(16383);
                5'd7:    a = ZW'(8192);
                5'd8:    a = ZW'(4096);
                5'd9:    a = ZW'(2048);
                5'd10:   a = ZW'(1024);
                5'd11:   a = ZW'(512);
                5'd12:   a = ZW'(256);
                5'd13:   a = ZW'(128);
                5'd14:   a = ZW'(64);
                5'd15:   a = ZW'(32);
                5'd16:   a = ZW'(16);
                5'd17:   a = ZW'(8);
                5'd18:   a = ZW'(4);
                5'd19:   a = ZW'(2);
                5'd20:   a = ZW'(1);
                5'd21:   a = ZW'(1);
                default: a = '0;
            endcase
            return a;
        end
    endfunction

    // row-major walk through the 3x3 matrix
    function automatic logic [1:0] mac_row(input logic [CNT_W-1:0] k);
        logic [1:0] r;
        begin
            case (k)
                4'd0, 4'd1, 4'd2: r = 2'd0;
                4'd3, 4'd4, 4'd5: r = 2'd1;
                default:          r = 2'd2;
            endcase
            return r;
        end
    endfunction

    function automatic logic [1:0] mac_col(input logic [CNT_W-1:0] k);
        logic [1:0] c;
        begin
            case (k)
                4'd0, 4'd3, 4'd6: c = 2'd0;
                4'd1, 4'd4, 4'd7: c = 2'd1;
                default:          c = 2'd2;
            endcase
            return c;
        end
    endfunction

endpackage

### hw/rtl/lsfc_cordic_cell.sv
module lsfc_cordic_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [lsfc_pkg::STEP_W-1:0] step,
    input  lsfc_pkg::cord_t             din,
    output lsfc_pkg::cord_t             dout
);
    import lsfc_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    cord_t                cell_next;
    cord_t                cell_reg;

    always_comb
    begin
        xs = din.x >>> step;
        ys = din.y >>> step;
        cell_next     = din;
        if (din.y > 0)
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
            cell_next.z = din.z + atan_q20(step);
        end
        else
        begin
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
            cell_next.z = din.z - atan_q20(step);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

    assign dout = cell_reg;

endmodule

### hw/rtl/lsfc_cordic_chain.sv
module lsfc_cordic_chain (
    input  logic            clk,
    input  logic            rst_n,
    input  lsfc_pkg::cord_t cin,
    output lsfc_pkg::cord_t cout
);
    import lsfc_pkg::*;

    cord_t pre_next;
    cord_t pre_reg;
    cord_t st [0:CORDIC_STEPS];

    // quadrant fold so the vector starts in the right half plane
    always_comb
    begin
        pre_next = cin;
        pre_next.z = '0;
        if (cin.x < 0)
        begin
            if (cin.y >= 0)
            begin
                pre_next.x = cin.y;
                pre_next.y = -cin.x;
                pre_next.z = ZW'(ANG_HALF_PI);
            end
            else
            begin
                pre_next.x = -cin.y;
                pre_next.y = cin.x;
                pre_next.z = -ZW'(ANG_HALF_PI);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_reg <= '0;
        else
            pre_reg <= pre_next;
    end

    assign st[0] = pre_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        lsfc_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (STEP_W'(g)),
            .din   (st[g]),
            .dout  (st[g+1])
        );
    end

    assign cout = st[CORDIC_STEPS];

endmodule

### hw/rtl/lsfc_body_rotate.sv
module lsfc_body_rotate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [lsfc_pkg::D_W-1:0]   dx,
    input  logic signed [lsfc_pkg::D_W-1:0]   dy,
    input  logic signed [lsfc_pkg::D_W-1:0]   dz,
    input  logic signed [lsfc_pkg::Q_W-1:0]   qx,
    input  logic signed [lsfc_pkg::Q_W-1:0]   qy,
    input  logic signed [lsfc_pkg::Q_W-1:0]   qz,
    input  logic signed [lsfc_pkg::Q_W-1:0]   qw,
    output logic                              done,
    output logic signed [lsfc_pkg::B_W-1:0]   bx,
    output logic signed [lsfc_pkg::B_W-1:0]   by,
    output logic signed [lsfc_pkg::B_W-1:0]   bz
);
    import lsfc_pkg::*;

    rot_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic signed [PROD_W-1:0] prod_reg [0:N_PROD-1];
    logic signed [Q_W-1:0]  op_a, op_b;
    logic signed [SUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [M_W-1:0]  m_sel;
    logic signed [D_W-1:0]  d_sel;
    logic signed [M_W-1:0]  m_reg;
    logic signed [D_W-1:0]  d_reg;
    logic signed [MUL_W-1:0] mul_reg;
    logic signed [B_W-1:0]  bx_reg, by_reg, bz_reg;
    logic signed [B_W-1:0]  acc_in, acc_sum;
    logic [CNT_W-1:0]       acc_idx;

    // products: ww xx yy zz xy wz xz wy yz wx
    always_comb
    begin
        case (cnt_reg)
            4'd0:    begin op_a = qw; op_b = qw; end
            4'd1:    begin op_a = qx; op_b = qx; end
            4'd2:    begin op_a = qy; op_b = qy; end
            4'd3:    begin op_a = qz; op_b = qz; end
            4'd4:    begin op_a = qx; op_b = qy; end
            4'd5:    begin op_a = qw; op_b = qz; end
            4'd6:    begin op_a = qx; op_b = qz; end
            4'd7:    begin op_a = qw; op_b = qy; end
            4'd8:    begin op_a = qy; op_b = qz; end
            default: begin op_a = qw; op_b = qx; end
        endcase
    end

    always_comb
    begin
        e00 = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) - SUM_W'(prod_reg[2])
              - SUM_W'(prod_reg[3]);
        e11 = SUM_W'(prod_reg[0]) - SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
              - SUM_W'(prod_reg[3]);
        e22 = SUM_W'(prod_reg[0]) - SUM_W'(prod_reg[1]) - SUM_W'(prod_reg[2])
              + SUM_W'(prod_reg[3]);
        e01 = SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5]);
        e10 = SUM_W'(prod_reg[4]) - SUM_W'(prod_reg[5]);
        e02 = SUM_W'(prod_reg[6]) - SUM_W'(prod_reg[7]);
        e20 = SUM_W'(prod_reg[6]) + SUM_W'(prod_reg[7]);
        e12 = SUM_W'(prod_reg[8]) + SUM_W'(prod_reg[9]);
        e21 = SUM_W'(prod_reg[8]) - SUM_W'(prod_reg[9]);
        // off-diagonal terms carry the factor of two, so shift one less
        case (cnt_reg)
            4'd0:    m_sel = M_W'(e00 >>> 14);
            4'd1:    m_sel = M_W'(e01 >>> 13);
            4'd2:    m_sel = M_W'(e02 >>> 13);
            4'd3:    m_sel = M_W'(e10 >>> 13);
            4'd4:    m_sel = M_W'(e11 >>> 14);
            4'd5:    m_sel = M_W'(e12 >>> 13);
            4'd6:    m_sel = M_W'(e20 >>> 13);
            4'd7:    m_sel = M_W'(e21 >>> 13);
            default: m_sel = M_W'(e22 >>> 14);
        endcase
        case (mac_col(cnt_reg))
            2'd0:    d_sel = dx;
            2'd1:    d_sel = dy;
            default: d_sel = dz;
        endcase
    end

    assign acc_idx = cnt_reg - CNT_W'(2);

    always_comb
    begin
        case (mac_row(acc_idx))
            2'd0:    acc_in = bx_reg;
            2'd1:    acc_in = by_reg;
            default: acc_in = bz_reg;
        endcase
        if (mac_col(acc_idx) == 2'd0)
            acc_sum = B_W'(mul_reg);
        else
            acc_sum = acc_in + B_W'(mul_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            R_IDLE:
            begin
                if (start)
                begin
                    state_next = R_PROD;
                    cnt_next   = '0;
                end
            end
            R_PROD:
            begin
                if (cnt_reg == CNT_W'(N_PROD - 1))
                begin
                    state_next = R_MAC;
                    cnt_next   = '0;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            R_MAC:
            begin
                // three-deep pipe: select, multiply, accumulate
                if (cnt_reg == CNT_W'(N_MAC + 1))
                begin
                    state_next = R_IDLE;
                    done_next  = 1'b1;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            default: state_next = R_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == R_PROD)
            prod_reg[cnt_reg] <= PROD_W'(op_a * op_b);
        if (state_reg == R_MAC)
        begin
            if (cnt_reg < CNT_W'(N_MAC))
            begin
                m_reg <= m_sel;
                d_reg <= d_sel;
            end
            if (cnt_reg >= CNT_W'(1) && cnt_reg <= CNT_W'(N_MAC))
                mul_reg <= MUL_W'(m_reg * d_reg);
            if (cnt_reg >= CNT_W'(2))
            begin
                case (mac_row(acc_idx))
                    2'd0:    bx_reg <= acc_sum;
                    2'd1:    by_reg <= acc_sum;
                    default: bz_reg <= acc_sum;
                endcase
            end
        end
    end

    assign done = done_reg;
    assign bx   = bx_reg;
    assign by   = by_reg;
    assign bz   = bz_reg;

    a_done_from_mac: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == R_MAC))
        else $error("done without matrix pass");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == R_IDLE)
        else $error("start while busy");
    a_prod_to_mac: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == R_PROD && state_next == R_MAC) |-> cnt_reg == CNT_W'(N_PROD - 1))
        else $error("product phase cut short");

endmodule

### hw/rtl/line_of_sight_fin_and_thrust_control.sv
// flow: an item without valid positions goes straight to the result; an item with valid
//   positions passes through the body rotation, the CORDIC cell chain and the fin limit
// throughput: one item at a time, the next only after the result is loaded into the output,
//   which waits while a previous result waits for out_ready; set by ten products on one
//   multiplier and nine matrix terms on a second one, then the CORDIC cell chain
// reset: thrust level 0, registers to their reset values, no result pending
module line_of_sight_fin_and_thrust_control (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [lsfc_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [lsfc_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           cmd,
    input  logic                                 own_valid,
    input  logic                                 target_valid,
    input  logic signed [31:0]                   own_x,
    input  logic signed [31:0]                   own_y,
    input  logic signed [31:0]                   own_z,
    input  logic signed [31:0]                   target_x,
    input  logic signed [31:0]                   target_y,
    input  logic signed [31:0]                   target_z,
    input  logic signed [15:0]                   quat_x,
    input  logic signed [15:0]                   quat_y,
    input  logic signed [30:0]                   quat_zw,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [15:0]                   thrust_out,
    output logic signed [14:0]                   pitch_out,
    output logic signed [14:0]                   yaw_out,
    output logic                                 tracking
);
    import lsfc_pkg::*;

    top_state_t               state_reg, state_next;
    logic signed [GAIN_W-1:0] pitch_gain_reg, yaw_gain_reg;
    logic [FIN_W-1:0]         fin_limit_reg;
    logic [INC_W-1:0]         thrust_inc_reg;
    logic signed [THR_W-1:0]  thrust_max_reg, thrust_min_reg;
    logic signed [THR_W-1:0]  thrust_level_reg, thrust_level_next;
    logic signed [THR_W+1:0]  tsum;
    logic                     in_accept, data_ok;
    logic signed [D_W-1:0]    dx_reg, dy_reg, dz_reg;
    logic signed [Q_W-1:0]    qx_reg, qy_reg, qz_reg, qw_reg;
    logic                     rot_start_reg;
    logic                     rot_done;
    logic signed [B_W-1:0]    bx, by, bz;
    logic                     inj_reg, inj_next;
    cord_t                    cin, cout;
    logic signed [GMUL_W-1:0] gmul_reg;
    logic                     gvld_reg, gtag_reg;
    logic signed [GMUL_W-1:0] rnd, lim;
    logic signed [ANG_W-1:0]  demand;
    logic                     fin_done;
    logic signed [ANG_W-1:0]  pitch_res_reg, yaw_res_reg;
    logic signed [THR_W-1:0]  thr_res_reg;
    logic                     trk_res_reg;
    logic                     out_valid_reg;
    logic signed [THR_W-1:0]  thrust_out_reg;
    logic signed [ANG_W-1:0]  pitch_out_reg, yaw_out_reg;
    logic                     tracking_reg;
    logic                     out_load;

    assign in_ready  = (state_reg == T_IDLE);
    assign in_accept = in_valid && in_ready;
    assign data_ok   = own_valid && target_valid;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_gain_reg <= GAIN_W'(256);
            yaw_gain_reg   <= GAIN_W'(256);
            fin_limit_reg  <= FIN_W'(1430);
            thrust_inc_reg <= INC_W'(26);
            thrust_max_reg <= THR_W'(256);
            thrust_min_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_idx))
                REG_PITCH_GAIN: pitch_gain_reg <= cfg_wdata;
                REG_YAW_GAIN:   yaw_gain_reg   <= cfg_wdata;
                REG_FIN_LIMIT:  fin_limit_reg  <= cfg_wdata[FIN_W-1:0];
                REG_THRUST_INC: thrust_inc_reg <= cfg_wdata[INC_W-1:0];
                REG_THRUST_MAX: thrust_max_reg <= cfg_wdata;
                REG_THRUST_MIN: thrust_min_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // throttle stepping, ceiling test first
    always_comb
    begin
        if (cmd_t'(cmd) == CMD_UP)
            tsum = (THR_W+2)'(thrust_level_reg) + (THR_W+2)'($signed({1'b0, thrust_inc_reg}));
        else
            tsum = (THR_W+2)'(thrust_level_reg) - (THR_W+2)'($signed({1'b0, thrust_inc_reg}));
        case (cmd_t'(cmd))
            CMD_UP, CMD_DOWN:
            begin
                if (tsum > (THR_W+2)'(thrust_max_reg))
                    thrust_level_next = thrust_max_reg;
                else if (tsum < (THR_W+2)'(thrust_min_reg))
                    thrust_level_next = thrust_min_reg;
                else
                    thrust_level_next = THR_W'(tsum);
            end
            CMD_STOP: thrust_level_next = '0;
            default:  thrust_level_next = thrust_level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thrust_level_reg <= '0;
        else if (in_accept)
            thrust_level_reg <= thrust_level_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dx_reg <= D_W'(target_x) - D_W'(own_x);
            dy_reg <= D_W'(target_y) - D_W'(own_y);
            dz_reg <= D_W'(target_z) - D_W'(own_z);
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= Q_W'($signed(quat_zw[Q_W+QZ_W-1:Q_W]));
            qw_reg <= $signed(quat_zw[Q_W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_start_reg <= 1'b0;
        else
            rot_start_reg <= in_accept && data_ok;
    end

    lsfc_body_rotate u_rot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start_reg),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .dz    (dz_reg),
        .qx    (qx_reg),
        .qy    (qy_reg),
        .qz    (qz_reg),
        .qw    (qw_reg),
        .done  (rot_done),
        .bx    (bx),
        .by    (by),
        .bz    (bz)
    );

    // pitch item first, yaw item on the next cycle
    always_comb
    begin
        cin.vld = (state_reg == T_CORD);
        cin.tag = inj_reg;
        cin.x   = CW'(by);
        cin.y   = inj_reg ? -CW'(bx) : CW'(bz);
        cin.z   = '0;
    end

    lsfc_cordic_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .cin   (cin),
        .cout  (cout)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gvld_reg <= 1'b0;
            gtag_reg <= 1'b0;
        end
        else
        begin
            gvld_reg <= cout.vld;
            gtag_reg <= cout.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cout.vld)
            gmul_reg <= GMUL_W'(cout.z * (cout.tag ? yaw_gain_reg : pitch_gain_reg));
    end

    always_comb
    begin
        rnd = (gmul_reg + GMUL_W'(32768)) >>> 16;
        lim = $signed({{(GMUL_W-FIN_W){1'b0}}, fin_limit_reg});
        if (rnd > lim)
            demand = ANG_W'(lim);
        else if (rnd < -lim)
            demand = ANG_W'(-lim);
        else
            demand = ANG_W'(rnd);
    end

    assign fin_done = gvld_reg && gtag_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            thr_res_reg   <= data_ok ? thrust_level_next : '0;
            trk_res_reg   <= data_ok;
            pitch_res_reg <= '0;
            yaw_res_reg   <= '0;
        end
        else if (gvld_reg)
        begin
            if (gtag_reg)
                yaw_res_reg <= demand;
            else
                pitch_res_reg <= demand;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        inj_next   = inj_reg;
        out_load   = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (in_accept)
                    state_next = data_ok ? T_ROT : T_DONE;
            end
            T_ROT:
            begin
                if (rot_done)
                begin
                    state_next = T_CORD;
                    inj_next   = 1'b0;
                end
            end
            T_CORD:
            begin
                inj_next = 1'b1;
                if (inj_reg)
                    state_next = T_FIN;
            end
            T_FIN:
            begin
                if (fin_done)
                    state_next = T_DONE;
            end
            T_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            inj_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            inj_reg   <= inj_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            thrust_out_reg <= thr_res_reg;
            pitch_out_reg  <= pitch_res_reg;
            yaw_out_reg    <= yaw_res_reg;
            tracking_reg   <= trk_res_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign thrust_out = thrust_out_reg;
    assign pitch_out  = pitch_out_reg;
    assign yaw_out    = yaw_out_reg;
    assign tracking   = tracking_reg;

    a_rot_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        rot_done |-> state_reg == T_ROT)
        else $error("rotation finished outside its phase");
    a_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
        fin_done |-> state_reg == T_FIN)
        else $error("yaw demand outside its phase");
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tracking_reg) |-> (pitch_out_reg == '0 && yaw_out_reg == '0
        && thrust_out_reg == '0))
        else $error("untracked item with nonzero demand");
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == T_DONE))
        else $error("item shown without finishing");

endmodule
